>>> src/zlhw_pkg.sv
// Shared types and constants for the archive local header walker.
// Used by the parser, the result queue, the top level and the testbench.
package zlhw_pkg;

   localparam int POSITION_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [31:0] LOCAL_SIGNATURE = 32'h04034B50;
   localparam logic [7:0]  DESCRIPTOR_FLAG = 8'h08;
   localparam logic [7:0]  SLASH = 8'h2F;
   localparam logic [7:0]  BACKSLASH = 8'h5C;

   localparam logic [4:0] HEADER_LEN = 5'd30;
   localparam logic [4:0] SIGNATURE_LEN = 5'd4;
   localparam logic [4:0] HDR_FLAGS = 5'd6;
   localparam logic [4:0] HDR_METHOD = 5'd8;
   localparam logic [4:0] HDR_COMPRESSED = 5'd18;
   localparam logic [4:0] HDR_UNCOMPRESSED = 5'd22;
   localparam logic [4:0] HDR_NAME_LEN = 5'd26;
   localparam logic [4:0] HDR_EXTRA_LEN = 5'd28;

   localparam logic KIND_ENTRY = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [2:0] {
      PHASE_SEARCH,
      PHASE_HEADER,
      PHASE_NAME,
      PHASE_EXTRA,
      PHASE_DATA,
      PHASE_DONE
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_NO_HEADER,
      STATUS_DESCRIPTOR,
      STATUS_TRUNCATED
   } status_type;

   typedef struct packed {
      logic        record_kind;
      status_type  status;
      logic [31:0] header_offset;
      logic [31:0] name_start;
      logic [15:0] name_bytes;
      logic [31:0] payload_start;
      logic [31:0] comp_bytes;
      logic [31:0] plain_bytes;
      logic [15:0] method;
      logic        readable;
      logic        last;
   } record_type;

   typedef struct packed {
      logic [1:0] count;
      record_type first;
      record_type second;
   } push_type;

endpackage

>>> src/zlhw_req_if.sv
// Input channel: one archive byte per word with its end mark.
// Standalone; no dependencies.
interface zlhw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] archive_byte;
   logic       end_of_archive;

   modport source (output valid, output archive_byte, output end_of_archive, input ready);
   modport sink (input valid, input archive_byte, input end_of_archive, output ready);
endinterface

>>> src/zlhw_rsp_if.sv
// Result channel: entry records and the final status record.
// Standalone; no dependencies.
interface zlhw_rsp_if;
   logic        valid;
   logic        ready;
   logic        record_kind;
   logic [1:0]  status;
   logic [31:0] header_offset;
   logic [31:0] name_start;
   logic [15:0] name_bytes;
   logic [31:0] payload_start;
   logic [31:0] comp_bytes;
   logic [31:0] plain_bytes;
   logic [15:0] method;
   logic        readable;
   logic        last;

   modport source (
      output valid, output record_kind, output status, output header_offset,
      output name_start, output name_bytes, output payload_start,
      output comp_bytes, output plain_bytes, output method,
      output readable, output last, input ready
   );
   modport sink (
      input valid, input record_kind, input status, input header_offset,
      input name_start, input name_bytes, input payload_start,
      input comp_bytes, input plain_bytes, input method,
      input readable, input last, output ready
   );
endinterface

>>> src/zip_local_header_walker.sv
// Archive local header walker: one archive byte per word, one word per cycle.
// A record is built combinationally from the byte that causes it and registered into
// the result queue. The last byte of an archive that also closes an entry yields two
// words, pushed into the queue together; the input stalls while the four-word result
// queue has fewer than two free slots. Synchronous reset returns the walker to
// searching for a signature and empties the queue.
module zip_local_header_walker #(
   parameter int POSITION_BITS = zlhw_pkg::POSITION_BITS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   zlhw_req_if.sink    req_channel,
   zlhw_rsp_if.source  rsp_channel
);

   zlhw_pkg::push_type   push;
   zlhw_pkg::record_type head;
   logic                 take;
   logic                 pop;
   logic                 not_empty;
   logic                 room;

   assign take = req_channel.valid && req_channel.ready;
   assign pop = rsp_channel.valid && rsp_channel.ready;
   assign req_channel.ready = room;

   zlhw_parser #(
      .POSITION_BITS(POSITION_BITS)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .take(take),
      .archive_byte(req_channel.archive_byte),
      .end_of_archive(req_channel.end_of_archive),
      .push(push)
   );

   zlhw_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .pop(pop),
      .head(head),
      .not_empty(not_empty),
      .room(room)
   );

   assign rsp_channel.valid = not_empty;
   assign rsp_channel.record_kind = head.record_kind;
   assign rsp_channel.status = head.status;
   assign rsp_channel.header_offset = head.header_offset;
   assign rsp_channel.name_start = head.name_start;
   assign rsp_channel.name_bytes = head.name_bytes;
   assign rsp_channel.payload_start = head.payload_start;
   assign rsp_channel.comp_bytes = head.comp_bytes;
   assign rsp_channel.plain_bytes = head.plain_bytes;
   assign rsp_channel.method = head.method;
   assign rsp_channel.readable = head.readable;
   assign rsp_channel.last = head.last;

endmodule

>>> src/zlhw_parser.sv
// Per-byte header walk: state registers, field capture and record build.
// Depends on zlhw_pkg.
module zlhw_parser #(
   parameter int POSITION_BITS = zlhw_pkg::POSITION_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [7:0]         archive_byte,
   input  logic               end_of_archive,
   output zlhw_pkg::push_type push
);

   zlhw_pkg::phase_type  phase_ff, phase_in, phase_step, seg_phase;
   zlhw_pkg::status_type final_status_ff, final_status_in, final_step;
   logic [31:0]              window_ff, window_in;
   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic [POSITION_BITS-1:0] entry_start_ff, entry_start_in;
   logic [4:0]               count_ff, count_in;
   logic [15:0]              method_ff, method_in;
   logic [31:0]              compressed_ff, compressed_in;
   logic [31:0]              uncompressed_ff, uncompressed_in;
   logic [15:0]              name_len_ff, name_len_in;
   logic [15:0]              extra_len_ff, extra_len_in;
   logic [31:0]              skip_ff, skip_in, seg_skip;
   logic [7:0]               last_name_ff, last_name_in;
   logic                     descriptor_ff, descriptor_in;
   logic                     seg_go;
   logic                     emit;
   logic [1:0]               comp_rel, uncomp_rel;
   logic [POSITION_BITS-1:0] name_off, data_off;
   zlhw_pkg::record_type     entry_rec, status_rec;
   zlhw_pkg::status_type     end_status;

   assign comp_rel = 2'(count_ff - zlhw_pkg::HDR_COMPRESSED);
   assign uncomp_rel = 2'(count_ff - zlhw_pkg::HDR_UNCOMPRESSED);

   always_comb begin
      phase_in = phase_ff;
      final_status_in = final_status_ff;
      window_in = window_ff;
      position_in = position_ff;
      entry_start_in = entry_start_ff;
      count_in = count_ff;
      method_in = method_ff;
      compressed_in = compressed_ff;
      uncompressed_in = uncompressed_ff;
      name_len_in = name_len_ff;
      extra_len_in = extra_len_ff;
      skip_in = skip_ff;
      last_name_in = last_name_ff;
      descriptor_in = descriptor_ff;
      seg_go = 1'b0;
      seg_phase = phase_ff;
      seg_skip = skip_ff;
      emit = 1'b0;
      if (take) begin
         position_in = position_ff + POSITION_BITS'(1);
         window_in = {archive_byte, window_ff[31:8]};
         unique case (phase_ff)
            zlhw_pkg::PHASE_SEARCH: begin
               if (window_in == zlhw_pkg::LOCAL_SIGNATURE) begin
                  phase_in = zlhw_pkg::PHASE_HEADER;
                  count_in = zlhw_pkg::SIGNATURE_LEN;
                  entry_start_in = position_ff - POSITION_BITS'(3);
                  descriptor_in = 1'b0;
               end
            end
            zlhw_pkg::PHASE_HEADER: begin
               count_in = count_ff + 5'd1;
               if (count_ff == zlhw_pkg::HDR_FLAGS) begin
                  descriptor_in = (archive_byte & zlhw_pkg::DESCRIPTOR_FLAG) != 8'd0;
               end
               if (count_ff == zlhw_pkg::HDR_METHOD) begin
                  method_in[7:0] = archive_byte;
               end
               if (count_ff == zlhw_pkg::HDR_METHOD + 5'd1) begin
                  method_in[15:8] = archive_byte;
               end
               if (count_ff >= zlhw_pkg::HDR_COMPRESSED &&
                   count_ff < zlhw_pkg::HDR_COMPRESSED + 5'd4) begin
                  compressed_in[{comp_rel, 3'b000} +: 8] = archive_byte;
               end
               if (count_ff >= zlhw_pkg::HDR_UNCOMPRESSED &&
                   count_ff < zlhw_pkg::HDR_UNCOMPRESSED + 5'd4) begin
                  uncompressed_in[{uncomp_rel, 3'b000} +: 8] = archive_byte;
               end
               if (count_ff == zlhw_pkg::HDR_NAME_LEN) begin
                  name_len_in[7:0] = archive_byte;
               end
               if (count_ff == zlhw_pkg::HDR_NAME_LEN + 5'd1) begin
                  name_len_in[15:8] = archive_byte;
               end
               if (count_ff == zlhw_pkg::HDR_EXTRA_LEN) begin
                  extra_len_in[7:0] = archive_byte;
               end
               if (count_ff == zlhw_pkg::HDR_EXTRA_LEN + 5'd1) begin
                  extra_len_in[15:8] = archive_byte;
               end
               if (count_in == zlhw_pkg::SIGNATURE_LEN &&
                   window_in != zlhw_pkg::LOCAL_SIGNATURE) begin
                  phase_in = zlhw_pkg::PHASE_DONE;
                  final_status_in = zlhw_pkg::STATUS_OK;
               end else if (count_in == zlhw_pkg::HEADER_LEN) begin
                  if (descriptor_in) begin
                     phase_in = zlhw_pkg::PHASE_DONE;
                     final_status_in = zlhw_pkg::STATUS_DESCRIPTOR;
                  end else begin
                     seg_go = 1'b1;
                     seg_phase = zlhw_pkg::PHASE_NAME;
                     seg_skip = {16'd0, name_len_in};
                  end
               end
            end
            zlhw_pkg::PHASE_NAME: begin
               last_name_in = archive_byte;
               seg_go = 1'b1;
               seg_skip = skip_ff - 32'd1;
            end
            zlhw_pkg::PHASE_EXTRA, zlhw_pkg::PHASE_DATA: begin
               seg_go = 1'b1;
               seg_skip = skip_ff - 32'd1;
            end
            zlhw_pkg::PHASE_DONE: begin
            end
            default: begin
            end
         endcase

         // Empty name, extra and data segments fall through within the same byte.
         if (seg_go) begin
            if (seg_phase == zlhw_pkg::PHASE_NAME && seg_skip == 32'd0) begin
               seg_phase = zlhw_pkg::PHASE_EXTRA;
               seg_skip = {16'd0, extra_len_in};
            end
            if (seg_phase == zlhw_pkg::PHASE_EXTRA && seg_skip == 32'd0) begin
               seg_phase = zlhw_pkg::PHASE_DATA;
               seg_skip = compressed_in;
            end
            if (seg_phase == zlhw_pkg::PHASE_DATA && seg_skip == 32'd0) begin
               emit = name_len_in != 16'd0 && last_name_in != zlhw_pkg::SLASH &&
                      last_name_in != zlhw_pkg::BACKSLASH;
               phase_in = zlhw_pkg::PHASE_HEADER;
               count_in = 5'd0;
               entry_start_in = position_in;
               descriptor_in = 1'b0;
            end else begin
               phase_in = seg_phase;
               skip_in = seg_skip;
            end
         end
      end
      phase_step = phase_in;
      final_step = final_status_in;
      if (take && end_of_archive) begin
         phase_in = zlhw_pkg::PHASE_SEARCH;
         final_status_in = zlhw_pkg::STATUS_OK;
         window_in = 32'd0;
         position_in = '0;
         count_in = 5'd0;
      end
   end

   always_comb begin
      name_off = entry_start_ff + POSITION_BITS'(zlhw_pkg::HEADER_LEN);
      data_off = name_off + POSITION_BITS'(name_len_in) + POSITION_BITS'(extra_len_in);

      entry_rec.record_kind = zlhw_pkg::KIND_ENTRY;
      entry_rec.status = zlhw_pkg::STATUS_OK;
      entry_rec.header_offset = 32'(entry_start_ff);
      entry_rec.name_start = 32'(name_off);
      entry_rec.name_bytes = name_len_in;
      entry_rec.payload_start = 32'(data_off);
      entry_rec.comp_bytes = compressed_in;
      entry_rec.plain_bytes = uncompressed_in;
      entry_rec.method = method_in;
      entry_rec.readable = method_in == 16'd0 && compressed_in == uncompressed_in;
      entry_rec.last = 1'b0;

      unique case (phase_step)
         zlhw_pkg::PHASE_SEARCH: end_status = zlhw_pkg::STATUS_NO_HEADER;
         zlhw_pkg::PHASE_HEADER: end_status = zlhw_pkg::STATUS_OK;
         zlhw_pkg::PHASE_DONE:   end_status = final_step;
         default:                end_status = zlhw_pkg::STATUS_TRUNCATED;
      endcase

      status_rec = '0;
      status_rec.record_kind = zlhw_pkg::KIND_STATUS;
      status_rec.status = end_status;
      status_rec.last = 1'b1;

      push.count = {1'b0, take && emit} + {1'b0, take && end_of_archive};
      push.first = emit ? entry_rec : status_rec;
      push.second = status_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= zlhw_pkg::PHASE_SEARCH;
         final_status_ff <= zlhw_pkg::STATUS_OK;
         window_ff <= 32'd0;
         position_ff <= '0;
         count_ff <= 5'd0;
      end else begin
         phase_ff <= phase_in;
         final_status_ff <= final_status_in;
         window_ff <= window_in;
         position_ff <= position_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_start_ff <= entry_start_in;
      method_ff <= method_in;
      compressed_ff <= compressed_in;
      uncompressed_ff <= uncompressed_in;
      name_len_ff <= name_len_in;
      extra_len_ff <= extra_len_in;
      skip_ff <= skip_in;
      last_name_ff <= last_name_in;
      descriptor_ff <= descriptor_in;
   end

endmodule

>>> src/zlhw_queue.sv
// Result queue: takes up to two records per cycle, hands out one per cycle while the receiver is ready.
// Depends on zlhw_pkg.
module zlhw_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  zlhw_pkg::push_type   push,
   input  logic                 pop,
   output zlhw_pkg::record_type head,
   output logic                 not_empty,
   output logic                 room
);

   localparam int DEPTH = zlhw_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   zlhw_pkg::record_type  mem [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   assign wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
   assign count_in = count_ff + COUNT_BITS'(push.count) - COUNT_BITS'(pop);

   assign head = mem[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign room = count_ff <= COUNT_BITS'(DEPTH - 2);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_ff + PTR_BITS'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> dv/zip_local_header_walker_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for zip_local_header_walker: drives archive bytes, predicts records.
// Depends on zlhw_pkg, the zlhw_req_if and zlhw_rsp_if interfaces and the walker itself.
module zip_local_header_walker_test;

   localparam int TARGET_WORDS = 700;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_LIMIT = 10;
   localparam logic [31:0] CENTRAL_SIGNATURE = 32'h02014B50;

   typedef struct packed {
      logic [7:0] value;
      logic       eoa;
   } archive_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   zlhw_req_if req_bus ();
   zlhw_rsp_if rsp_bus ();

   zip_local_header_walker uut (
      .clock(clock),
      .reset(reset),
      .req_channel(req_bus),
      .rsp_channel(rsp_bus)
   );

   logic       drv_valid = 1'b0;
   logic [7:0] drv_byte = 8'h00;
   logic       drv_end = 1'b0;
   logic       rsp_ready_q = 1'b0;

   assign req_bus.valid = drv_valid;
   assign req_bus.archive_byte = drv_byte;
   assign req_bus.end_of_archive = drv_end;
   assign rsp_bus.ready = rsp_ready_q;

   archive_word_type     pending_words[$];
   logic [7:0]           archive_buf[$];
   zlhw_pkg::record_type expected_records[$];
   int                   words_taken = 0;
   int                   failures = 0;
   int                   cycle_count = 0;
   int                   send_idle_pct = 0;
   int                   recv_stall_pct = 0;
   logic                 hold_arm = 1'b0;
   int                   hold_left = 0;

   // Walker state mirrored by the predictor.
   zlhw_pkg::phase_type  walk_phase;
   logic [31:0]          sig_window;
   logic [31:0]          position;
   logic [31:0]          entry_offset;
   logic [31:0]          skip_left;
   logic [31:0]          hdr_compressed;
   logic [31:0]          hdr_uncompressed;
   logic [15:0]          hdr_method;
   logic [15:0]          hdr_name_len;
   logic [15:0]          hdr_extra_len;
   logic [4:0]           hdr_index;
   logic [7:0]           tail_char;
   zlhw_pkg::status_type done_status;
   logic                 uses_descriptor;

   task automatic append_byte(input logic [7:0] b);
      archive_buf.insert(archive_buf.size(), b);
   endtask

   task automatic clear_walker();
      walk_phase = zlhw_pkg::PHASE_SEARCH;
      sig_window = '0;
      position = '0;
      entry_offset = '0;
      skip_left = '0;
      hdr_compressed = '0;
      hdr_uncompressed = '0;
      hdr_method = '0;
      hdr_name_len = '0;
      hdr_extra_len = '0;
      hdr_index = '0;
      tail_char = '0;
      done_status = zlhw_pkg::STATUS_OK;
      uses_descriptor = 1'b0;
   endtask

   task automatic open_entry(input logic [31:0] start, input logic [4:0] seen);
      walk_phase = zlhw_pkg::PHASE_HEADER;
      hdr_index = seen;
      entry_offset = start;
      hdr_method = '0;
      hdr_compressed = '0;
      hdr_uncompressed = '0;
      hdr_name_len = '0;
      hdr_extra_len = '0;
      uses_descriptor = 1'b0;
   endtask

   task automatic take_header_byte(input logic [7:0] b);
      int k;
      k = int'(hdr_index);
      if (hdr_index == zlhw_pkg::HDR_FLAGS && (b & zlhw_pkg::DESCRIPTOR_FLAG) != 0)
         uses_descriptor = 1'b1;
      if (k >= int'(zlhw_pkg::HDR_METHOD) && k < int'(zlhw_pkg::HDR_METHOD) + 2)
         hdr_method[8 * (k - int'(zlhw_pkg::HDR_METHOD)) +: 8] = b;
      if (k >= int'(zlhw_pkg::HDR_COMPRESSED) && k < int'(zlhw_pkg::HDR_COMPRESSED) + 4)
         hdr_compressed[8 * (k - int'(zlhw_pkg::HDR_COMPRESSED)) +: 8] = b;
      if (k >= int'(zlhw_pkg::HDR_UNCOMPRESSED) && k < int'(zlhw_pkg::HDR_UNCOMPRESSED) + 4)
         hdr_uncompressed[8 * (k - int'(zlhw_pkg::HDR_UNCOMPRESSED)) +: 8] = b;
      if (k >= int'(zlhw_pkg::HDR_NAME_LEN) && k < int'(zlhw_pkg::HDR_NAME_LEN) + 2)
         hdr_name_len[8 * (k - int'(zlhw_pkg::HDR_NAME_LEN)) +: 8] = b;
      if (k >= int'(zlhw_pkg::HDR_EXTRA_LEN) && k < int'(zlhw_pkg::HDR_EXTRA_LEN) + 2)
         hdr_extra_len[8 * (k - int'(zlhw_pkg::HDR_EXTRA_LEN)) +: 8] = b;
   endtask

   // Steps over empty name, extra and data fields; an entry is due once its data has passed.
   task automatic close_segments();
      zlhw_pkg::record_type rec;
      logic                 moving;
      moving = 1'b1;
      while (moving) begin
         moving = 1'b0;
         if (skip_left == 0) begin
            case (walk_phase)
               zlhw_pkg::PHASE_NAME: begin
                  walk_phase = zlhw_pkg::PHASE_EXTRA;
                  skip_left = 32'(hdr_extra_len);
                  moving = 1'b1;
               end
               zlhw_pkg::PHASE_EXTRA: begin
                  walk_phase = zlhw_pkg::PHASE_DATA;
                  skip_left = hdr_compressed;
                  moving = 1'b1;
               end
               zlhw_pkg::PHASE_DATA: begin
                  if (hdr_name_len != 0 && tail_char != zlhw_pkg::SLASH &&
                      tail_char != zlhw_pkg::BACKSLASH) begin
                     rec = '0;
                     rec.record_kind = zlhw_pkg::KIND_ENTRY;
                     rec.status = zlhw_pkg::STATUS_OK;
                     rec.header_offset = entry_offset;
                     rec.name_start = entry_offset + 32'(zlhw_pkg::HEADER_LEN);
                     rec.name_bytes = hdr_name_len;
                     rec.payload_start = entry_offset + 32'(zlhw_pkg::HEADER_LEN)
                                         + 32'(hdr_name_len) + 32'(hdr_extra_len);
                     rec.comp_bytes = hdr_compressed;
                     rec.plain_bytes = hdr_uncompressed;
                     rec.method = hdr_method;
                     rec.readable = (hdr_method == 0) && (hdr_compressed == hdr_uncompressed);
                     rec.last = 1'b0;
                     expected_records.insert(expected_records.size(), rec);
                  end
                  open_entry(position, 5'd0);
               end
               default: ;
            endcase
         end
      end
   endtask

   task automatic walk_word(input logic [7:0] b, input logic eoa);
      logic [31:0]          here;
      zlhw_pkg::record_type rec;
      here = position;
      position = position + 32'd1;
      sig_window = {b, sig_window[31:8]};
      case (walk_phase)
         zlhw_pkg::PHASE_SEARCH: begin
            if (sig_window == zlhw_pkg::LOCAL_SIGNATURE)
               open_entry(here - 32'(zlhw_pkg::SIGNATURE_LEN) + 32'd1,
                          zlhw_pkg::SIGNATURE_LEN);
         end
         zlhw_pkg::PHASE_HEADER: begin
            take_header_byte(b);
            hdr_index = hdr_index + 5'd1;
            if (hdr_index == zlhw_pkg::SIGNATURE_LEN &&
                sig_window != zlhw_pkg::LOCAL_SIGNATURE) begin
               walk_phase = zlhw_pkg::PHASE_DONE;
               done_status = zlhw_pkg::STATUS_OK;
            end else if (hdr_index >= zlhw_pkg::HEADER_LEN) begin
               if (uses_descriptor) begin
                  walk_phase = zlhw_pkg::PHASE_DONE;
                  done_status = zlhw_pkg::STATUS_DESCRIPTOR;
               end else begin
                  walk_phase = zlhw_pkg::PHASE_NAME;
                  skip_left = 32'(hdr_name_len);
                  close_segments();
               end
            end
         end
         zlhw_pkg::PHASE_NAME: begin
            tail_char = b;
            skip_left = skip_left - 32'd1;
            close_segments();
         end
         zlhw_pkg::PHASE_EXTRA, zlhw_pkg::PHASE_DATA: begin
            skip_left = skip_left - 32'd1;
            close_segments();
         end
         default: ;
      endcase
      if (eoa) begin
         rec = '0;
         rec.record_kind = zlhw_pkg::KIND_STATUS;
         rec.last = 1'b1;
         case (walk_phase)
            zlhw_pkg::PHASE_SEARCH: rec.status = zlhw_pkg::STATUS_NO_HEADER;
            zlhw_pkg::PHASE_HEADER: rec.status = zlhw_pkg::STATUS_OK;
            zlhw_pkg::PHASE_DONE:   rec.status = done_status;
            default:                rec.status = zlhw_pkg::STATUS_TRUNCATED;
         endcase
         expected_records.insert(expected_records.size(), rec);
         clear_walker();
      end
   endtask

   function automatic string show_record(input zlhw_pkg::record_type r);
      return $sformatf({"kind=%0d status=%0d hdr=%h name=%h len=%h data=%h ",
                        "csize=%h usize=%h method=%h readable=%0d last=%0d"},
                       r.record_kind, r.status, r.header_offset, r.name_start,
                       r.name_bytes, r.payload_start, r.comp_bytes,
                       r.plain_bytes, r.method, r.readable, r.last);
   endfunction

   task automatic put_le(input logic [31:0] value, input int count);
      for (int i = 0; i < count; i++)
         append_byte(value[8 * i +: 8]);
   endtask

   task automatic put_noise(input int count);
      repeat (count) append_byte(8'($urandom));
   endtask

   task automatic put_header(input logic [31:0] sig, input logic [15:0] flags,
                             input logic [15:0] method, input logic [31:0] csize,
                             input logic [31:0] usize, input logic [15:0] nlen,
                             input logic [15:0] xlen);
      put_le(sig, 4);
      put_le($urandom, 2);
      put_le(32'(flags), 2);
      put_le(32'(method), 2);
      put_le($urandom, 4);
      put_le($urandom, 4);
      put_le(csize, 4);
      put_le(usize, 4);
      put_le(32'(nlen), 2);
      put_le(32'(xlen), 2);
   endtask

   function automatic logic [31:0] pick_wide();
      case ($urandom_range(3))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_method();
      case ($urandom_range(4))
         0: return 16'hFFFF;
         1: return 16'($urandom);
         default: return 16'h0000;
      endcase
   endfunction

   // One entry, header only when stopped; stopped is set when its flags announce a data descriptor.
   task automatic put_entry(output bit stopped);
      logic [15:0] nlen;
      logic [15:0] xlen;
      logic [15:0] method;
      logic [15:0] flags;
      logic [31:0] csize;
      logic [31:0] usize;
      logic [7:0]  tail;
      tail = 8'h00;
      nlen = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
      xlen = 16'($urandom_range(0, 3));
      csize = 32'($urandom_range(0, 6));
      method = pick_method();
      case ($urandom_range(4))
         0: usize = pick_wide();
         1: usize = csize + 32'd1;
         default: usize = csize;
      endcase
      flags = 16'($urandom) & ~16'(zlhw_pkg::DESCRIPTOR_FLAG);
      if ($urandom_range(11) == 0)
         flags = flags | 16'(zlhw_pkg::DESCRIPTOR_FLAG);
      put_header(zlhw_pkg::LOCAL_SIGNATURE, flags, method, csize, usize, nlen, xlen);
      stopped = (flags & 16'(zlhw_pkg::DESCRIPTOR_FLAG)) != 0;
      if (!stopped) begin
         for (int i = 0; i < int'(nlen); i++) begin
            tail = 8'($urandom);
            if (i == int'(nlen) - 1) begin
               case ($urandom_range(9))
                  0: tail = zlhw_pkg::SLASH;
                  1: tail = zlhw_pkg::BACKSLASH;
                  default: ;
               endcase
            end
            append_byte(tail);
         end
         put_noise(int'(xlen) + int'(csize));
      end
   endtask

   task automatic ship_archive();
      archive_word_type w;
      for (int i = 0; i < archive_buf.size(); i++) begin
         w.value = archive_buf[i];
         w.eoa = (i == archive_buf.size() - 1);
         pending_words.insert(pending_words.size(), w);
      end
      archive_buf.delete();
   endtask

   task automatic put_random_archive();
      int          entries;
      int          cut;
      bit          stopped;
      logic [15:0] flags;
      stopped = 1'b0;
      case ($urandom_range(19))
         0, 1, 2: put_noise($urandom_range(1, 20));
         3, 4: begin
            put_le(zlhw_pkg::LOCAL_SIGNATURE, 4);
            put_noise($urandom_range(0, 40));
         end
         5, 6: begin
            // Oversized fields: mostly ends inside the name or the data.
            flags = 16'($urandom) & ~16'(zlhw_pkg::DESCRIPTOR_FLAG);
            put_header(zlhw_pkg::LOCAL_SIGNATURE, flags, pick_method(), pick_wide(),
                       pick_wide(), 16'($urandom), 16'($urandom));
            put_noise($urandom_range(0, 12));
         end
         default: begin
            put_noise($urandom_range(0, 6));
            entries = $urandom_range(1, 3);
            for (int e = 0; e < entries && !stopped; e++)
               put_entry(stopped);
            if (stopped)
               put_noise($urandom_range(0, 5));
            case ($urandom_range(5))
               0: begin
                  put_le(CENTRAL_SIGNATURE, 4);
                  put_noise($urandom_range(0, 8));
               end
               1: begin
                  put_le(zlhw_pkg::LOCAL_SIGNATURE, 4);
                  put_noise($urandom_range(0, 25));
               end
               2: begin
                  cut = $urandom_range(1, 8);
                  while (cut > 0 && archive_buf.size() > 1) begin
                     void'(archive_buf.pop_back());
                     cut--;
                  end
               end
               3: begin
                  put_le(zlhw_pkg::LOCAL_SIGNATURE ^ (32'd1 << $urandom_range(31)), 4);
                  put_noise($urandom_range(0, 6));
               end
               default: ;
            endcase
         end
      endcase
      if (archive_buf.size() == 0)
         append_byte(8'($urandom));
      ship_archive();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else if (!drv_valid || req_bus.ready) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drv_valid <= 1'b1;
            drv_byte <= pending_words[0].value;
            drv_end <= pending_words[0].eoa;
            void'(pending_words.pop_front());
         end else begin
            drv_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_arm)
         hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ready_q <= 1'b0;
      else
         rsp_ready_q <= !hold_arm && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
   end

   always @(posedge clock) begin
      zlhw_pkg::record_type seen;
      zlhw_pkg::record_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_ready_q) begin
            seen.record_kind = rsp_bus.record_kind;
            seen.status = zlhw_pkg::status_type'(rsp_bus.status);
            seen.header_offset = rsp_bus.header_offset;
            seen.name_start = rsp_bus.name_start;
            seen.name_bytes = rsp_bus.name_bytes;
            seen.payload_start = rsp_bus.payload_start;
            seen.comp_bytes = rsp_bus.comp_bytes;
            seen.plain_bytes = rsp_bus.plain_bytes;
            seen.method = rsp_bus.method;
            seen.readable = rsp_bus.readable;
            seen.last = rsp_bus.last;
            if (expected_records.size() == 0) begin
               if (failures < REPORT_LIMIT)
                  $display("Unexpected record: %s", show_record(seen));
               failures++;
            end else begin
               want = expected_records.pop_front();
               if (seen !== want) begin
                  if (failures < REPORT_LIMIT) begin
                     $display("Record mismatch, expected: %s", show_record(want));
                     $display("                   actual: %s", show_record(seen));
                  end
                  failures++;
               end
            end
         end
         if (drv_valid && req_bus.ready) begin
            words_taken <= words_taken + 1;
            walk_word(drv_byte, drv_end);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int total;
      clear_walker();

      // Lone bytes at both extremes: no signature anywhere.
      append_byte(8'h00);
      ship_archive();
      append_byte(8'hFF);
      ship_archive();
      // A signature on the very last bytes, then a header cut short.
      put_le(zlhw_pkg::LOCAL_SIGNATURE, 4);
      ship_archive();
      put_le(zlhw_pkg::LOCAL_SIGNATURE, 4);
      repeat (10) append_byte(8'hFF);
      ship_archive();

      while (pending_words.size() < TARGET_WORDS)
         put_random_archive();
      total = pending_words.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (words_taken >= total / 6);
      send_idle_pct = 78;
      wait (words_taken >= total / 3);
      send_idle_pct = 0;
      // The receiver holds off while bytes keep coming, so the result queue fills.
      hold_arm <= 1'b1;
      @(posedge clock);
      hold_arm <= 1'b0;
      @(posedge clock);
      wait (hold_left == 0);
      wait (words_taken >= total / 2);
      recv_stall_pct = 78;
      wait (words_taken >= 2 * total / 3);
      send_idle_pct = 6;
      recv_stall_pct = 6;
      wait (words_taken >= 5 * total / 6);
      send_idle_pct = 0;
      recv_stall_pct = 0;

      while (pending_words.size() != 0 || drv_valid)
         @(posedge clock);
      while (expected_records.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

>>> sim.f
src/zlhw_pkg.sv
src/zlhw_req_if.sv
src/zlhw_rsp_if.sv
src/zlhw_parser.sv
src/zlhw_queue.sv
src/zip_local_header_walker.sv
dv/zip_local_header_walker_test.sv
